// File: design/vlcbp_pkg.sv
// Shared types and constants for the variable-length code bit packer.
package vlcbp_pkg;

	// Field widths of the input and result transactions.
	localparam int CODE_W       = 64;
	localparam int LEN_W        = 7;
	localparam int BYTE_W       = 8;
	localparam int MAX_CODE_LEN = 64;

	// Staged word: up to seven pending bits followed by a full code, left aligned.
	localparam int WORD_W  = CODE_W + BYTE_W;
	localparam int NBYTE_W = 4;
	localparam int MAX_BYTES_PER_ITEM = 8;

	// Queue between the front and back halves.
	localparam int Q_DEPTH = 4;
	localparam int Q_PTR_W = $clog2(Q_DEPTH);
	localparam int Q_CNT_W = Q_PTR_W + 1;

	// Request codes.
	localparam logic REQ_APPEND = 1'b0;
	localparam logic REQ_FLUSH  = 1'b1;

	// One queued job: a left-aligned bit word and the number of whole bytes in it.
	typedef struct packed {
		logic [WORD_W-1:0]  word;
		logic [NBYTE_W-1:0] nbytes;
	} q_entry_t;

	// Queue status seen by both sides.
	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage

// File: design/vlcbp_front.sv
// Front half: accepts requests, merges code bits with the pending bits and queues byte jobs.
module vlcbp_front (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic                            req_type,
	input  logic [vlcbp_pkg::CODE_W-1:0]    code_value,
	input  logic [vlcbp_pkg::LEN_W-1:0]     code_length,
	input  vlcbp_pkg::q_status_t            q_stat,
	output logic                            push,
	output vlcbp_pkg::q_entry_t             push_entry
);
	import vlcbp_pkg::*;

	// Pending bits are kept left aligned in a byte; unused low bits are zero.
	logic [BYTE_W-1:0]  pend_q;
	logic [2:0]         cnt_q;

	logic               accept;
	logic [LEN_W-1:0]   len_sat;
	logic [LEN_W-1:0]   shamt;
	logic [CODE_W-1:0]  code_la;
	logic [WORD_W-1:0]  word;
	logic [LEN_W-1:0]   total;
	logic [NBYTE_W-1:0] nbytes;
	logic [WORD_W-1:0]  rest;
	logic [BYTE_W-1:0]  pend_d;
	logic [2:0]         cnt_d;

	assign in_stall = q_stat.full;
	assign accept   = in_valid & ~q_stat.full;

	// Saturate the length and left-align the code so that bits above the length drop out.
	always_comb begin
		len_sat = (code_length > LEN_W'(MAX_CODE_LEN)) ? LEN_W'(MAX_CODE_LEN) : code_length;
		shamt   = LEN_W'(CODE_W) - len_sat;
		code_la = code_value << shamt;
	end

	// Place the code right behind the pending bits and split off whole bytes.
	always_comb begin
		word   = {pend_q, {CODE_W{1'b0}}} | ({code_la, {BYTE_W{1'b0}}} >> cnt_q);
		total  = {{(LEN_W-3){1'b0}}, cnt_q} + len_sat;
		nbytes = total[LEN_W-1:3];
		rest   = word << {nbytes, 3'b000};
		pend_d = rest[WORD_W-1 -: BYTE_W];
		cnt_d  = total[2:0];
	end

	// Queue a job for every transaction that produces at least one byte.
	always_comb begin
		if (req_type == REQ_FLUSH) begin
			push              = accept & (cnt_q != 3'd0);
			push_entry.word   = {pend_q, {CODE_W{1'b0}}};
			push_entry.nbytes = NBYTE_W'(1);
		end else begin
			push              = accept & (nbytes != '0);
			push_entry.word   = word;
			push_entry.nbytes = nbytes;
		end
	end

	// Pending state update.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
			cnt_q  <= '0;
		end else if (accept) begin
			if (req_type == REQ_FLUSH) begin
				pend_q <= '0;
				cnt_q  <= '0;
			end else begin
				pend_q <= pend_d;
				cnt_q  <= cnt_d;
			end
		end
	end

	// With nothing pending the pending byte must be all zeros.
	a_empty_pend_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 3'd0) |-> (pend_q == '0))
		else $error("pending bits present while pending count is zero");

endmodule

// File: design/vlcbp_fifo.sv
// Short job queue between the front and back halves.
module vlcbp_fifo (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  vlcbp_pkg::q_entry_t  push_entry,
	input  logic                 pop,
	output vlcbp_pkg::q_entry_t  head,
	output vlcbp_pkg::q_status_t q_stat
);
	import vlcbp_pkg::*;

	q_entry_t           entries_q [Q_DEPTH];
	logic [Q_PTR_W-1:0] wr_ptr_q;
	logic [Q_PTR_W-1:0] rd_ptr_q;
	logic [Q_CNT_W-1:0] count_q;

	assign head         = entries_q[rd_ptr_q];
	assign q_stat.full  = (count_q == Q_CNT_W'(Q_DEPTH));
	assign q_stat.empty = (count_q == '0);

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_entry;
		end
	end

	// Pointers and occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_stat.full)
		else $error("job queued while queue is full");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_stat.empty)
		else $error("job taken from an empty queue");

endmodule

// File: design/vlcbp_back.sv
// Back half: takes queued jobs and sends their bytes one per cycle while out_stall is low.
module vlcbp_back (
	input  logic                           clk,
	input  logic                           arst_n,
	input  vlcbp_pkg::q_entry_t            head,
	input  vlcbp_pkg::q_status_t           q_stat,
	output logic                           pop,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [vlcbp_pkg::BYTE_W-1:0]   out_byte,
	output logic                           last_byte
);
	import vlcbp_pkg::*;

	logic [WORD_W-1:0]  sh_q;
	logic [NBYTE_W-1:0] rem_q;
	logic               fire;

	// The current byte always sits in the top of the shift register.
	assign out_valid = (rem_q != '0);
	assign out_byte  = sh_q[WORD_W-1 -: BYTE_W];
	assign last_byte = (rem_q == NBYTE_W'(1));
	assign fire      = out_valid & ~out_stall;

	// Load the next job when idle or as the last byte of the current one leaves.
	assign pop = ~q_stat.empty & (~out_valid | (last_byte & fire));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
		end else if (pop) begin
			rem_q <= head.nbytes;
		end else if (fire) begin
			rem_q <= rem_q - 1'b1;
		end
	end

	// Byte shifter, payload only.
	always_ff @(posedge clk) begin
		if (pop) begin
			sh_q <= head.word;
		end else if (fire) begin
			sh_q <= sh_q << BYTE_W;
		end
	end

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rem_q <= NBYTE_W'(MAX_BYTES_PER_ITEM))
		else $error("byte count of a job out of range");

	a_load_valid: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> out_valid)
		else $error("loaded job did not present a byte");

endmodule

// File: design/variable_length_code_bit_packer_core.sv
// MSB-first variable-length code bit packer, top level.
// Append transactions (req_type 0) add the low code_length bits of code_value, most
// significant first, behind up to seven pending bits; lengths above 64 count as 64. Every
// completed byte comes out on out_byte with the earliest bit in bit 7, and last_byte marks
// the final byte caused by one transaction. A flush transaction (req_type 1) sends the
// pending bits zero padded as one byte, if any are pending, and clears them. The front
// takes one transaction per cycle while the queue is not full, finishing its bit merge in
// that cycle, and hands jobs to a four-entry queue; the back sends one byte per cycle while
// out_stall is low, so a transaction yields n bytes (0 to 8 for an append, 0 or 1 for a
// flush), and the sustained rate is set by that byte-wide output. When the queue and
// output are idle, a transaction's first byte passes through a queue entry and then the
// back shift register before it appears; in_stall rises only while the queue is full.
module variable_length_code_bit_packer_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          req_type,
	input  logic [vlcbp_pkg::CODE_W-1:0]  code_value,
	input  logic [vlcbp_pkg::LEN_W-1:0]   code_length,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [vlcbp_pkg::BYTE_W-1:0]  out_byte,
	output logic                          last_byte
);
	import vlcbp_pkg::*;

	logic      push;
	logic      pop;
	q_entry_t  push_entry;
	q_entry_t  head;
	q_status_t q_stat;

	// Request intake and bit merge.
	vlcbp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.req_type   (req_type),
		.code_value (code_value),
		.code_length(code_length),
		.q_stat     (q_stat),
		.push       (push),
		.push_entry (push_entry)
	);

	// Job queue.
	vlcbp_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_entry(push_entry),
		.pop       (pop),
		.head      (head),
		.q_stat    (q_stat)
	);

	// Byte output.
	vlcbp_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.q_stat   (q_stat),
		.pop      (pop),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_byte (out_byte),
		.last_byte(last_byte)
	);

endmodule

// File: tb/variable_length_code_bit_packer_core_tb.sv
// Self-checking testbench for the MSB-first variable-length code bit packer.
module variable_length_code_bit_packer_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import vlcbp_pkg::*;

	// One input transaction as queued for the driver.
	typedef struct {
		logic              req;
		logic [CODE_W-1:0] code;
		logic [LEN_W-1:0]  len;
	} pack_req_t;

	// One expected output byte.
	typedef struct {
		logic [BYTE_W-1:0] data;
		logic              last;
	} packed_byte_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic                 req_type = REQ_APPEND;
	logic [CODE_W-1:0]    code_value = '0;
	logic [LEN_W-1:0]     code_length = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic [BYTE_W-1:0]    out_byte;
	logic                 last_byte;

	pack_req_t    pending_reqs[$];
	packed_byte_t expected_bytes[$];

	// Predictor state: bits not yet forming a whole byte, newest bit in bit 0.
	logic [6:0] held_bits = '0;
	logic [2:0] held_count = '0;

	int mismatches = 0;
	int items_sent = 0;
	int cycle_count = 0;
	int in_gap = 0;
	int out_gap = 0;

	variable_length_code_bit_packer_core DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.req_type    (req_type),
		.code_value  (code_value),
		.code_length (code_length),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_byte    (out_byte),
		.last_byte   (last_byte)
	);

	// Free-running clock, 10 ns period.
	initial begin
		forever #5 clk = ~clk;
	end

	// Works out the bytes that one accepted transaction produces.
	task automatic pack_item(input logic req, input logic [CODE_W-1:0] code,
			input logic [LEN_W-1:0] len);
		packed_byte_t fresh[$];
		packed_byte_t b;
		logic [7:0]   acc;
		int           cnt;
		int           eff;
		acc = {1'b0, held_bits};
		cnt = held_count;
		if (req == REQ_FLUSH) begin
			if (cnt != 0) begin
				b.data = acc << (8 - cnt);
				b.last = 1'b1;
				expected_bytes.push_back(b);
			end
			held_bits = '0;
			held_count = '0;
		end else begin
			eff = (len > MAX_CODE_LEN) ? MAX_CODE_LEN : int'(len);
			for (int i = eff; i > 0; i--) begin
				acc = {acc[6:0], code[i-1]};
				cnt++;
				if (cnt == 8) begin
					b.data = acc;
					b.last = 1'b0;
					fresh.push_back(b);
					acc = '0;
					cnt = 0;
				end
			end
			if (fresh.size() > 0) begin
				fresh[fresh.size()-1].last = 1'b1;
			end
			foreach (fresh[k]) begin
				expected_bytes.push_back(fresh[k]);
			end
			held_bits = acc[6:0];
			held_count = cnt[2:0];
		end
	endtask

	task automatic add_req(input logic req, input logic [CODE_W-1:0] code,
			input logic [LEN_W-1:0] len);
		pack_req_t r;
		r.req = req;
		r.code = code;
		r.len = len;
		pending_reqs.push_back(r);
	endtask

	// Driver: presents queued transactions and holds them while stalled.
	always @(posedge clk) begin
		pack_req_t r;
		bit        quiet;
		bit        calm;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				pack_item(req_type, code_value, code_length);
				items_sent++;
			end
			if (!in_valid || !in_stall) begin
				quiet = pending_reqs.size() < 60;
				calm = ((items_sent / 50) % 3) == 1;
				if (in_gap > 0) begin
					in_gap--;
					in_valid <= 1'b0;
				end else if (!quiet && !calm && $urandom_range(0, 4) == 0) begin
					in_gap = $urandom_range(0, 2);
					in_valid <= 1'b0;
				end else if (pending_reqs.size() > 0) begin
					r = pending_reqs.pop_front();
					req_type <= r.req;
					code_value <= r.code;
					code_length <= r.len;
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: checks each accepted byte and drives random output stalls.
	always @(posedge clk) begin
		packed_byte_t e;
		bit           quiet;
		bit           calm;
		cycle_count++;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_bytes.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("Unexpected byte %h last %b at %0t", out_byte, last_byte,
							$realtime);
					end
				end else begin
					e = expected_bytes.pop_front();
					if (out_byte !== e.data || last_byte !== e.last) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("Byte mismatch at %0t: expected %h last %b, got %h last %b",
								$realtime, e.data, e.last, out_byte, last_byte);
						end
					end
				end
			end
			quiet = pending_reqs.size() < 60;
			calm = ((cycle_count / 150) % 3) == 1;
			if (out_gap > 0) begin
				out_gap--;
				out_stall <= 1'b1;
			end else if (!quiet && !calm && $urandom_range(0, 4) == 0) begin
				out_gap = $urandom_range(0, 2);
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// Stimulus, reset and end of run.
	initial begin
		logic [CODE_W-1:0] code;
		int                sel;
		int                len;
		// Flush with nothing pending, then zero-length appends.
		add_req(REQ_FLUSH, {$urandom, $urandom}, 7'd127);
		add_req(REQ_APPEND, '1, 7'd0);
		add_req(REQ_APPEND, '0, 7'd0);
		// Bits above the length are ignored; flush pads the partial byte.
		add_req(REQ_APPEND, '1, 7'd3);
		add_req(REQ_FLUSH, '1, 7'd64);
		add_req(REQ_APPEND, 64'h5, 7'd1);
		add_req(REQ_FLUSH, '0, 7'd0);
		// Exact byte boundaries leave nothing pending.
		add_req(REQ_APPEND, 64'hFFFF_FFFF_FFFF_FF00, 7'd8);
		add_req(REQ_APPEND, 64'h55, 7'd7);
		add_req(REQ_APPEND, 64'h1, 7'd1);
		add_req(REQ_FLUSH, '1, 7'd5);
		// Full-length codes, alone and behind seven pending bits.
		add_req(REQ_APPEND, '1, 7'd64);
		add_req(REQ_APPEND, '0, 7'd64);
		add_req(REQ_APPEND, 64'h7F, 7'd7);
		add_req(REQ_APPEND, 64'hA5A5_5A5A_0F0F_F0F0, 7'd64);
		add_req(REQ_FLUSH, '0, 7'd0);
		// Lengths above the maximum saturate.
		add_req(REQ_APPEND, {$urandom, $urandom}, 7'd127);
		add_req(REQ_APPEND, 64'h1, 7'd3);
		add_req(REQ_APPEND, '1, 7'd65);
		add_req(REQ_APPEND, {$urandom, $urandom}, 7'd100);
		add_req(REQ_FLUSH, '1, 7'd127);
		// Random part: mostly short codes, some long, saturated, empty and flushes.
		for (int n = 0; n < 400; n++) begin
			sel = $urandom_range(0, 99);
			code = {$urandom, $urandom};
			if ($urandom_range(0, 19) == 0) begin
				code = '1;
			end else if ($urandom_range(0, 19) == 0) begin
				code = '0;
			end
			if (sel < 8) begin
				add_req(REQ_FLUSH, code, 7'($urandom_range(0, 127)));
			end else begin
				if (sel < 12) begin
					len = 0;
				end else if (sel < 70) begin
					len = $urandom_range(1, 16);
				end else if (sel < 85) begin
					len = $urandom_range(17, 63);
				end else if (sel < 93) begin
					len = 64;
				end else begin
					len = $urandom_range(65, 127);
				end
				add_req(REQ_APPEND, code, 7'(len));
			end
		end
		add_req(REQ_FLUSH, '0, 7'd0);

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_reqs.size() != 0 || in_valid) @(posedge clk);
		while (expected_bytes.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);

		if (mismatches == 0 && expected_bytes.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

	// Watchdog for a hung run.
	initial begin
		#2000000;
		$display("== FAIL ==");
		$finish;
	end

endmodule
